### sv/ibc_pkg.sv
// ----------------------------------------------------------------------------
// ibc_pkg
// Shared types and constants of the interval box classifier: register
// indexes, operation codes, hit count width and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package ibc_pkg;

	localparam int COUNT_BITS = 5;
	localparam int CFG_BITS   = 5;
	localparam int IDX_BITS   = 2;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = 5'd31;
	localparam logic [COUNT_BITS-1:0] CLASS_NONE = 5'h1F;

	localparam logic [IDX_BITS-1:0] REG_CLASS_COUNT   = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_KEY_COUNT     = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_WRITE_PROTECT = 2'd2;

	localparam logic OP_WRITE   = 1'b0;
	localparam logic OP_FEATURE = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_CLEAR = 3'b010,
		ST_SCAN  = 3'b100
	} state_t;

endpackage

`default_nettype wire

### sv/ibc_box_store.sv
// ----------------------------------------------------------------------------
// ibc_box_store
// Interval table: one entry per class and key holding a presence flag and
// the inclusive lower and upper bounds; one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ibc_box_store #(
	parameter int VALUE_BITS = 32,
	parameter int DEPTH      = 256,
	parameter int AW         = 8
) (
	input  wire logic                         clk,
	input  wire logic                         we,
	input  wire logic [AW-1:0]                waddr,
	input  wire logic                         wpresent,
	input  wire logic signed [VALUE_BITS-1:0] wlow,
	input  wire logic signed [VALUE_BITS-1:0] whigh,
	input  wire logic [AW-1:0]                raddr,
	output      logic                         rpresent,
	output      logic signed [VALUE_BITS-1:0] rlow,
	output      logic signed [VALUE_BITS-1:0] rhigh
);

	localparam int EW = 2 * VALUE_BITS + 1;

	logic [EW-1:0] mem [DEPTH];
	logic [EW-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= {wpresent, wlow, whigh};
		end
		rd_q <= mem[raddr];
	end

	assign rpresent = rd_q[EW-1];
	assign rlow     = $signed(rd_q[EW-2:VALUE_BITS]);
	assign rhigh    = $signed(rd_q[VALUE_BITS-1:0]);

endmodule

`default_nettype wire

### sv/interval_box_classifier.sv
// ----------------------------------------------------------------------------
// interval_box_classifier
// Box classifier: counts, per class, the feature values that fall inside the
// stored interval of their key and reports the best class on the last one.
// ----------------------------------------------------------------------------
//
//  channel   ports                                             timing
//  -------   -----------------------------------------------   --------------
//  command   start, busy, op, class_index, key_index,          start & !busy
//            low_bound, high_bound, feature_value, last_feature
//  result    done, class_id, best_count                        one-cycle strobe
//  config    cfg_we, cfg_index, cfg_data                       cfg_we, no wait
//
//  interval words may follow back to back; a write does not raise busy
//  a feature word holds busy while it scans min(class_count, MAX_CLASSES) classes
//  (all MAX_CLASSES when last, none when no class is in use and not last),
//  one class per cycle through the interval table read port
//  the result strobe rises at the same edge at which busy falls on a last feature
//  after reset busy stays high while the interval table is cleared
//  the result side cannot stall; done is shown for one cycle only
//
`default_nettype none

module interval_box_classifier #(
	parameter int MAX_CLASSES = 16,
	parameter int MAX_KEYS    = 16,
	parameter int VALUE_BITS  = 32
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output      logic                                busy,
	input  wire logic                                op,
	input  wire logic [3:0]                          class_index,
	input  wire logic [3:0]                          key_index,
	input  wire logic signed [31:0]                  low_bound,
	input  wire logic signed [31:0]                  high_bound,
	input  wire logic signed [31:0]                  feature_value,
	input  wire logic                                last_feature,
	output      logic                                done,
	output      logic signed [4:0]                   class_id,
	output      logic [4:0]                          best_count,
	input  wire logic                                cfg_we,
	input  wire logic [ibc_pkg::IDX_BITS-1:0]        cfg_index,
	input  wire logic [ibc_pkg::CFG_BITS-1:0]        cfg_data
);

	localparam int ENTRIES = MAX_CLASSES * MAX_KEYS;
	localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CW      = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int UW      = $clog2(MAX_CLASSES + 1);
	localparam int NB      = ibc_pkg::COUNT_BITS;

	ibc_pkg::state_t state_q;

	logic [ibc_pkg::CFG_BITS-1:0] class_count_q;
	logic [ibc_pkg::CFG_BITS-1:0] key_count_q;
	logic                         write_protect_q;

	logic [AW-1:0]                clr_q;
	logic [CW-1:0]                c_q;
	logic [CW-1:0]                c_end_q;
	logic [3:0]                   key_q;
	logic                         key_ok_q;
	logic                         last_q;
	logic signed [VALUE_BITS-1:0] val_q;

	logic                         v_s1;
	logic                         fin_s1;
	logic [CW-1:0]                c_s1;
	logic [NB-1:0]                cnt_s1;

	logic [NB-1:0]                best_q;
	logic [CW-1:0]                bid_q;

	logic                         done_q;
	logic [NB-1:0]                class_id_q;
	logic [NB-1:0]                best_count_q;

	logic [NB-1:0]                hit_mem [MAX_CLASSES];

	logic                         accept;
	logic [UW-1:0]                used;
	logic                         key_ok_in;
	logic                         cls_ok_in;
	logic                         tw_en;
	logic [AW-1:0]                tw_addr;
	logic                         tw_present;
	logic signed [VALUE_BITS-1:0] lo_ext;
	logic signed [VALUE_BITS-1:0] hi_ext;
	logic [AW-1:0]                tr_addr;
	logic                         rd_present;
	logic signed [VALUE_BITS-1:0] rd_low;
	logic signed [VALUE_BITS-1:0] rd_high;

	logic                         in_use;
	logic                         hit;
	logic [NB-1:0]                cnt_nx;
	logic [NB-1:0]                best_nx;
	logic [CW-1:0]                bid_nx;
	logic                         report;
	logic                         hw_en;
	logic [CW-1:0]                hw_addr;
	logic [NB-1:0]                hw_data;

	assign busy   = (state_q != ibc_pkg::ST_IDLE) || v_s1;
	assign accept = start && !busy;

	assign used = (int'(class_count_q) > MAX_CLASSES) ? UW'(MAX_CLASSES) : UW'(class_count_q);

	assign key_ok_in = int'(key_index) < MAX_KEYS;
	assign cls_ok_in = int'(class_index) < MAX_CLASSES;

	assign lo_ext = VALUE_BITS'(low_bound);
	assign hi_ext = VALUE_BITS'(high_bound);

	// table write: clearing sweep after reset, interval words otherwise
	always_comb begin
		tw_en      = 1'b0;
		tw_addr    = clr_q;
		tw_present = 1'b0;
		if (state_q == ibc_pkg::ST_CLEAR) begin
			tw_en = 1'b1;
		end else if (accept && op == ibc_pkg::OP_WRITE && !write_protect_q
				&& cls_ok_in && key_ok_in) begin
			tw_en      = 1'b1;
			tw_addr    = AW'(int'(class_index) * MAX_KEYS + int'(key_index));
			tw_present = 1'b1;
		end
	end

	assign tr_addr = AW'(int'(c_q) * MAX_KEYS + int'(key_q));

	ibc_box_store #(
		.VALUE_BITS (VALUE_BITS),
		.DEPTH      (ENTRIES),
		.AW         (AW)
	) u_store (
		.clk      (clk),
		.we       (tw_en),
		.waddr    (tw_addr),
		.wpresent (tw_present),
		.wlow     (lo_ext),
		.whigh    (hi_ext),
		.raddr    (tr_addr),
		.rpresent (rd_present),
		.rlow     (rd_low),
		.rhigh    (rd_high)
	);

	// class update in the stage after the table read
	assign in_use = int'(c_s1) < int'(used);
	assign hit    = key_ok_q && in_use && rd_present && (val_q >= rd_low) && (val_q <= rd_high);
	assign cnt_nx = (hit && cnt_s1 != ibc_pkg::COUNT_MAX) ? cnt_s1 + NB'(1) : cnt_s1;

	always_comb begin
		best_nx = best_q;
		bid_nx  = bid_q;
		if (v_s1 && last_q && in_use && cnt_nx > best_q) begin
			best_nx = cnt_nx;
			bid_nx  = c_s1;
		end
	end

	assign report = v_s1 && fin_s1 && last_q && (used != '0);

	always_comb begin
		hw_en   = 1'b0;
		hw_addr = c_s1;
		hw_data = '0;
		if (state_q == ibc_pkg::ST_CLEAR) begin
			hw_en   = int'(clr_q) < MAX_CLASSES;
			hw_addr = CW'(clr_q);
		end else if (v_s1) begin
			hw_en   = 1'b1;
			hw_data = last_q ? '0 : cnt_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (hw_en) begin
			hit_mem[hw_addr] <= hw_data;
		end
		cnt_s1 <= hit_mem[c_q];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q   <= 5'd16;
			key_count_q     <= 5'd16;
			write_protect_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ibc_pkg::REG_CLASS_COUNT:   class_count_q   <= cfg_data;
				ibc_pkg::REG_KEY_COUNT:     key_count_q     <= cfg_data;
				ibc_pkg::REG_WRITE_PROTECT: write_protect_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ibc_pkg::ST_CLEAR;
			clr_q   <= '0;
			c_q     <= '0;
			v_s1    <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			v_s1   <= 1'b0;
			done_q <= report;
			unique case (state_q)
				ibc_pkg::ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (int'(clr_q) == ENTRIES - 1) begin
						state_q <= ibc_pkg::ST_IDLE;
					end
				end
				ibc_pkg::ST_IDLE: begin
					c_q <= '0;
					if (accept && op == ibc_pkg::OP_FEATURE && (last_feature || used != '0)) begin
						state_q <= ibc_pkg::ST_SCAN;
					end
				end
				ibc_pkg::ST_SCAN: begin
					v_s1 <= 1'b1;
					c_q  <= c_q + CW'(1);
					if (c_q == c_end_q) begin
						state_q <= ibc_pkg::ST_IDLE;
					end
				end
				default: state_q <= ibc_pkg::ST_IDLE;
			endcase
		end
	end

	// word and pass registers
	always_ff @(posedge clk) begin
		fin_s1 <= (c_q == c_end_q);
		c_s1   <= c_q;
		if (accept && op == ibc_pkg::OP_FEATURE) begin
			key_q    <= key_index;
			key_ok_q <= key_ok_in;
			last_q   <= last_feature;
			val_q    <= VALUE_BITS'(feature_value);
			c_end_q  <= last_feature ? CW'(MAX_CLASSES - 1) : CW'(int'(used) - 1);
			best_q   <= '0;
			bid_q    <= '0;
		end else begin
			best_q <= best_nx;
			bid_q  <= bid_nx;
		end
		if (report) begin
			best_count_q <= best_nx;
			class_id_q   <= (best_nx == '0 || best_nx != key_count_q)
				? ibc_pkg::CLASS_NONE : NB'(bid_nx);
		end
	end

	assign done       = done_q;
	assign class_id   = $signed(class_id_q);
	assign best_count = best_count_q;

	// read and write-back of the hit counts never meet on one class
	assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && state_q == ibc_pkg::ST_SCAN) |-> (c_q != c_s1))
		else $error("hit count read overlaps write-back");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(v_s1) && $past(fin_s1) && $past(last_q)))
		else $error("result without a finished last-feature pass");

	assert property (@(posedge clk) disable iff (!arst_n)
		(done && class_id_q != ibc_pkg::CLASS_NONE) |-> (best_count == key_count_q))
		else $error("class reported without a full match");

endmodule

`default_nettype wire

### verif/interval_box_classifier_tb.sv
// ----------------------------------------------------------------------------
// interval_box_classifier_tb
// Self-checking bench for the interval box classifier. The whole interval
// table is filled first. A short directed run follows, then random objects
// under several register settings and sender idle rates. A scoreboard class
// predicts every result and compares it with the result strobe.
// ----------------------------------------------------------------------------

module interval_box_classifier_tb;

	localparam int MAX_CLASSES = 16;
	localparam int MAX_KEYS    = 16;
	localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic signed [4:0] id;
		logic [4:0]        hits;
	} verdict_t;

	class box_scoreboard;
		logic signed [31:0]             lo_tab [MAX_CLASSES][MAX_KEYS];
		logic signed [31:0]             hi_tab [MAX_CLASSES][MAX_KEYS];
		bit                             set_tab [MAX_CLASSES][MAX_KEYS];
		logic [ibc_pkg::COUNT_BITS-1:0] hits [MAX_CLASSES];
		logic [ibc_pkg::CFG_BITS-1:0]   n_classes;
		logic [ibc_pkg::CFG_BITS-1:0]   n_keys;
		bit                             wp;
		verdict_t                       due_q[$];
		int errors, words, writes, results, matched, saturated;

		function new();
			foreach (hits[i]) hits[i] = '0;
			n_classes = 5'd16;
			n_keys = 5'd16;
			wp = 1'b0;
		endfunction

		function void write_reg(input logic [ibc_pkg::IDX_BITS-1:0] idx,
				input logic [ibc_pkg::CFG_BITS-1:0] val);
			case (idx)
				ibc_pkg::REG_CLASS_COUNT:   n_classes = val;
				ibc_pkg::REG_KEY_COUNT:     n_keys = val;
				ibc_pkg::REG_WRITE_PROTECT: wp = val[0];
				default: ;
			endcase
		endfunction

		function void note_word(input logic o, input logic [3:0] c, input logic [3:0] k,
				input logic signed [31:0] lo, input logic signed [31:0] hi,
				input logic signed [31:0] v, input logic lst);
			int used;
			int top;
			logic [ibc_pkg::COUNT_BITS-1:0] best;
			verdict_t due;
			words++;
			if (o == ibc_pkg::OP_WRITE) begin
				if (!wp) begin
					lo_tab[c][k] = lo;
					hi_tab[c][k] = hi;
					set_tab[c][k] = 1'b1;
					writes++;
				end
				return;
			end
			used = (int'(n_classes) > MAX_CLASSES) ? MAX_CLASSES : int'(n_classes);
			for (int i = 0; i < used; i++)
				if (set_tab[i][k] && v >= lo_tab[i][k] && v <= hi_tab[i][k]
						&& hits[i] != ibc_pkg::COUNT_MAX)
					hits[i]++;
			if (!lst)
				return;
			best = '0;
			top = -1;
			for (int i = 0; i < used; i++)
				if (hits[i] > best) begin
					best = hits[i];
					top = i;
				end
			foreach (hits[i]) hits[i] = '0;
			if (used == 0)
				return;
			due.hits = best;
			due.id = (top < 0 || best != n_keys) ? ibc_pkg::CLASS_NONE : top[4:0];
			due_q.push_back(due);
		endfunction

		function void check_result(input logic signed [4:0] id, input logic [4:0] cnt);
			verdict_t due;
			if (due_q.size() == 0) begin
				errors++;
				if (errors < 200)
					$display("%0t: unexpected result, expected none, got class_id %0d best_count %0d",
						$time, id, cnt);
				return;
			end
			due = due_q.pop_front();
			results++;
			if (due.id != ibc_pkg::CLASS_NONE)
				matched++;
			if (due.hits == ibc_pkg::COUNT_MAX)
				saturated++;
			if (id !== due.id) begin
				errors++;
				if (errors < 200)
					$display("%0t: class_id mismatch, expected %0d, got %0d", $time, due.id, id);
			end
			if (cnt !== due.hits) begin
				errors++;
				if (errors < 200)
					$display("%0t: best_count mismatch, expected %0d, got %0d", $time, due.hits, cnt);
			end
		endfunction

		function int pending();
			return due_q.size();
		endfunction
	endclass

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            op;
	logic [3:0]                      class_index;
	logic [3:0]                      key_index;
	logic signed [31:0]              low_bound;
	logic signed [31:0]              high_bound;
	logic signed [31:0]              feature_value;
	logic                            last_feature;
	logic                            done;
	logic signed [4:0]               class_id;
	logic [4:0]                      best_count;
	logic                            cfg_we;
	logic [ibc_pkg::IDX_BITS-1:0]    cfg_index;
	logic [ibc_pkg::CFG_BITS-1:0]    cfg_data;

	box_scoreboard sb;
	int idle_pct;
	int seg_cfg [6][3] = '{'{16, 16, 0}, '{1, 1, 0}, '{16, 4, 0}, '{31, 31, 0},
		'{5, 16, 1}, '{9, 3, 0}};
	int phase_idle [3] = '{0, 81, 8};

	interval_box_classifier dut (.*);

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (done)
				sb.check_result(class_id, best_count);
			if (cfg_we)
				sb.write_reg(cfg_index, cfg_data);
			if (start && !busy)
				sb.note_word(op, class_index, key_index, low_bound, high_bound,
					feature_value, last_feature);
		end
	end

	task automatic send_word(input logic o, input logic [3:0] c, input logic [3:0] k,
			input logic signed [31:0] lo, input logic signed [31:0] hi,
			input logic signed [31:0] v, input logic lst);
		bit taken;
		while ($urandom_range(99) < idle_pct) begin
			start = 1'b0;
			@(negedge clk);
		end
		start = 1'b1;
		op = o;
		class_index = c;
		key_index = k;
		low_bound = lo;
		high_bound = hi;
		feature_value = v;
		last_feature = lst;
		do begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end while (!taken);
	endtask

	task automatic put_entry(input int c, input int k, input logic signed [31:0] lo,
			input logic signed [31:0] hi);
		send_word(ibc_pkg::OP_WRITE, c[3:0], k[3:0], lo, hi, $urandom(),
			1'($urandom_range(1)));
	endtask

	task automatic put_feature(input int k, input logic signed [31:0] v, input logic lst);
		send_word(ibc_pkg::OP_FEATURE, 4'($urandom_range(15)), k[3:0], $urandom(), $urandom(),
			v, lst);
	endtask

	task automatic set_reg(input logic [ibc_pkg::IDX_BITS-1:0] idx,
			input logic [ibc_pkg::CFG_BITS-1:0] val);
		start = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (MAX_CLASSES + 4) @(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	function automatic logic signed [31:0] pick_value(input int c, input int k, input bit miss);
		longint lo, hi, span;
		lo = sb.lo_tab[c][k];
		hi = sb.hi_tab[c][k];
		if (miss)
			case ($urandom_range(2))
				0: return 32'(lo - 1);
				1: return 32'(hi + 1);
				default: return $urandom();
			endcase
		if (lo > hi)
			return $urandom();
		span = hi - lo + 1;
		case ($urandom_range(5))
			0: return 32'(lo);
			1: return 32'(hi);
			default: return 32'(lo + longint'({32'd0, $urandom()} % span));
		endcase
	endfunction

	function automatic void random_interval(output logic signed [31:0] lo,
			output logic signed [31:0] hi);
		logic signed [31:0] a, b;
		a = $urandom();
		b = $urandom();
		case ($urandom_range(4))
			0: begin
				lo = (a < b) ? a : b;
				hi = (a < b) ? b : a;
			end
			1: begin
				lo = a;
				hi = a + $urandom_range(65536);
			end
			2: begin
				lo = (a < b) ? b : a;
				hi = (a < b) ? a : b;
			end
			3: begin
				lo = VAL_MIN;
				hi = VAL_MAX;
			end
			default: begin
				lo = a;
				hi = a;
			end
		endcase
	endfunction

	task automatic send_object(input int target, input int miss_pct);
		int keys [MAX_KEYS];
		int n, kc, j, tmp, k;
		bit full;
		kc = int'(sb.n_keys);
		full = kc >= 1 && kc <= MAX_KEYS;
		for (int i = 0; i < MAX_KEYS; i++)
			keys[i] = i;
		for (int i = MAX_KEYS - 1; i > 0; i--) begin
			j = $urandom_range(i);
			tmp = keys[i];
			keys[i] = keys[j];
			keys[j] = tmp;
		end
		n = full ? kc : $urandom_range(1, 6);
		for (int i = 0; i < n; i++) begin
			k = full ? keys[i] : $urandom_range(MAX_KEYS - 1);
			put_feature(k, pick_value(target, k, $urandom_range(99) < miss_pct), i == n - 1);
		end
	endtask

	// one key repeated up to or past the counter limit
	task automatic long_object(input int target);
		int k, n;
		k = $urandom_range(MAX_KEYS - 1);
		n = $urandom_range(31, 40);
		put_entry(target, k, $urandom() | 32'h8000_0000, $urandom() & 32'h7FFF_FFFF);
		for (int i = 0; i < n; i++)
			put_feature(k, pick_value(target, k, 1'b0), i == n - 1);
	endtask

	task automatic noise_object();
		int n;
		logic o;
		n = $urandom_range(1, 5);
		repeat (n) begin
			o = 1'($urandom_range(1));
			send_word(o, 4'($urandom_range(15)), 4'($urandom_range(15)), $urandom(), $urandom(),
				$urandom(), (o == ibc_pkg::OP_WRITE) ? 1'($urandom_range(1)) : 1'b0);
		end
		put_feature($urandom_range(MAX_KEYS - 1), $urandom(), 1'b1);
	endtask

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		logic signed [31:0] lo, hi;
		int target, r, mark, used;
		sb = new();
		arst_n = 1'b0;
		start = 1'b0;
		op = 1'b0;
		class_index = '0;
		key_index = '0;
		low_bound = '0;
		high_bound = '0;
		feature_value = '0;
		last_feature = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		idle_pct = 0;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;

		// every entry written before any feature word reads it
		for (int c = 0; c < MAX_CLASSES; c++)
			for (int k = 0; k < MAX_KEYS; k++) begin
				random_interval(lo, hi);
				put_entry(c, k, lo, hi);
			end

		put_entry(0, 0, VAL_MIN, VAL_MAX);
		put_entry(15, 15, VAL_MAX, VAL_MAX);
		put_entry(1, 0, 32'sd5, -32'sd5);
		put_entry(2, 0, VAL_MIN, VAL_MIN);
		set_reg(ibc_pkg::REG_KEY_COUNT, 5'd1);
		put_feature(0, VAL_MIN, 1'b1);
		put_feature(15, VAL_MAX, 1'b1);
		put_feature(0, 32'sd0, 1'b1);
		set_reg(ibc_pkg::REG_WRITE_PROTECT, 5'd1);
		put_entry(0, 0, 32'sd1, 32'sd1);
		put_feature(0, -32'sd7, 1'b1);
		set_reg(ibc_pkg::REG_WRITE_PROTECT, 5'd0);
		set_reg(ibc_pkg::REG_KEY_COUNT, 5'd0);
		put_feature(0, 32'sd3, 1'b1);
		set_reg(ibc_pkg::REG_KEY_COUNT, 5'd2);
		put_feature(0, 32'sd9, 1'b0);
		put_feature(0, -32'sd9, 1'b1);
		set_reg(ibc_pkg::REG_CLASS_COUNT, 5'd0);
		put_feature(3, $urandom(), 1'b0);
		put_feature(0, 32'sd1, 1'b1);
		set_reg(ibc_pkg::REG_CLASS_COUNT, 5'd31);
		set_reg(ibc_pkg::REG_KEY_COUNT, 5'd3);
		send_object(0, 0);

		for (int ph = 0; ph < 3; ph++) begin
			idle_pct = phase_idle[ph];
			for (int s = 0; s < 2; s++) begin
				set_reg(ibc_pkg::REG_CLASS_COUNT, 5'(seg_cfg[ph * 2 + s][0]));
				set_reg(ibc_pkg::REG_KEY_COUNT, 5'(seg_cfg[ph * 2 + s][1]));
				set_reg(ibc_pkg::REG_WRITE_PROTECT, 5'(seg_cfg[ph * 2 + s][2]));
				used = (int'(sb.n_classes) > MAX_CLASSES) ? MAX_CLASSES : int'(sb.n_classes);
				mark = sb.words;
				while (sb.words - mark < 150) begin
					target = $urandom_range(used - 1);
					r = $urandom_range(99);
					if (r < 12) begin
						repeat ($urandom_range(1, 3)) begin
							random_interval(lo, hi);
							put_entry($urandom_range(15), $urandom_range(15), lo, hi);
						end
					end else if (r < 22)
						noise_object();
					else if (r < 27 || (int'(sb.n_keys) > MAX_KEYS && r < 60))
						long_object(target);
					else
						send_object(target, 10);
				end
			end
		end

		start = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (MAX_CLASSES + 4) @(negedge clk);
		$display("covered %0d words, %0d stored intervals, %0d results, %0d full matches, %0d saturated",
			sb.words, sb.writes, sb.results, sb.matched, sb.saturated);
		$display("settings swept: class count 0 to 31, key count 0 to 31, write protect on and off");
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
